// ===== rtl/rau_pkg.sv =====
// Shared types and command codes for the rational accumulator unit.
// No dependencies; imported by rau_core and the top level.
package rau_pkg;

    typedef logic [2:0] rau_cmd_t;

    localparam rau_cmd_t CMD_LOAD    = 3'd0;
    localparam rau_cmd_t CMD_ADD     = 3'd1;
    localparam rau_cmd_t CMD_MUL     = 3'd2;
    localparam rau_cmd_t CMD_PREINC  = 3'd3;
    localparam rau_cmd_t CMD_POSTINC = 3'd4;
    localparam rau_cmd_t CMD_CMP     = 3'd5;
    localparam rau_cmd_t CMD_ADD_NU  = 3'd6;
    localparam rau_cmd_t CMD_MUL_NU  = 3'd7;

    // Core status toward the stream wrapper.
    typedef struct packed {
        logic idle;   // core can take a new command word
        logic done;   // result regs valid and handed over this cycle
    } rau_stat_t;

endpackage

// ===== rtl/rau_alu.sv =====
// Shared add/subtract unit of the rational accumulator unit.
// No dependencies; instanced once by rau_core.
module rau_alu #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic                 sub,
    output logic [WORD_BITS-1:0] sum,
    output logic                 carry
);

    logic [WORD_BITS-1:0] b_eff;

    // Subtract as a + ~b + 1; carry out high means a >= b (unsigned).
    assign b_eff = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + (WORD_BITS+1)'(sub);

endmodule

// ===== rtl/rau_core.sv =====
// Sequencer and datapath registers of the rational accumulator unit.
// Depends on rau_pkg and rau_alu (the single shared adder).
module rau_core #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rau_pkg::rau_cmd_t    cmd,
    input  logic [WORD_BITS-1:0] opd_n,
    input  logic [WORD_BITS-1:0] opd_d,
    input  logic                 out_free,
    output rau_pkg::rau_stat_t   stat,
    output logic [WORD_BITS-1:0] res_n,
    output logic [WORD_BITS-1:0] res_d,
    output logic                 res_eq
);

    import rau_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int K_W   = $clog2(WORD_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MLOAD = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_ADDP  = 4'd3;
    localparam logic [3:0] ST_INC   = 4'd4;
    localparam logic [3:0] ST_RCHK  = 4'd5;
    localparam logic [3:0] ST_GTWO  = 4'd6;
    localparam logic [3:0] ST_GCD   = 4'd7;
    localparam logic [3:0] ST_GSHL  = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    // Product slots: numerator term, cross term (add only), denominator.
    localparam logic [1:0] P_FIRST = 2'd0;
    localparam logic [1:0] P_CROSS = 2'd1;
    localparam logic [1:0] P_DEN   = 2'd2;

    logic [3:0]           state_reg, state_next;
    rau_cmd_t             cmd_reg, cmd_next;
    logic                 phase_reg, phase_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 dsel_reg, dsel_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [WORD_BITS-1:0] acc_n_reg, acc_n_next;
    logic [WORD_BITS-1:0] acc_d_reg, acc_d_next;

    logic [WORD_BITS-1:0] opd_n_reg, opd_n_next;
    logic [WORD_BITS-1:0] opd_d_reg, opd_d_next;
    logic [WORD_BITS-1:0] rn_reg, rn_next;
    logic [WORD_BITS-1:0] rd_reg, rd_next;
    logic [WORD_BITS-1:0] ta_reg, ta_next;
    logic [WORD_BITS-1:0] tb_reg, tb_next;
    logic [WORD_BITS-1:0] mcand_reg, mcand_next;
    logic [WORD_BITS-1:0] mplier_reg, mplier_next;
    logic [WORD_BITS-1:0] prod_reg, prod_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] res_n_reg, res_n_next;
    logic [WORD_BITS-1:0] res_d_reg, res_d_next;
    logic                 res_eq_reg, res_eq_next;

    logic [WORD_BITS-1:0] alu_a, alu_b, alu_sum;
    logic                 alu_sub, alu_carry;
    logic [WORD_BITS-1:0] div_shift, quo_new;
    logic                 is_add, is_upd, rn_pos, rd_pos;

    rau_alu #(.WORD_BITS(WORD_BITS)) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign is_add    = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_ADD_NU);
    assign is_upd    = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_MUL) || (cmd_reg == CMD_PREINC);
    assign rn_pos    = (rn_reg != '0) && !rn_reg[WORD_BITS-1];
    assign rd_pos    = (rd_reg != '0) && !rd_reg[WORD_BITS-1];
    assign div_shift = {rem_reg[WORD_BITS-2:0], quo_reg[WORD_BITS-1]};
    assign quo_new   = {quo_reg[WORD_BITS-2:0], alu_carry};

    // Operand steering for the shared adder.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_INC:
            begin
                alu_a = acc_n_reg;
                alu_b = acc_d_reg;
            end
            ST_MUL:
            begin
                alu_a = prod_reg;
                alu_b = mplier_reg[0] ? mcand_reg : '0;
            end
            ST_ADDP:
            begin
                alu_a = rn_reg;
                alu_b = prod_reg;
            end
            ST_GCD:
            begin
                alu_a   = ta_reg;
                alu_b   = tb_reg;
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_a   = div_shift;
                alu_b   = ta_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        dsel_next   = dsel_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        acc_n_next  = acc_n_reg;
        acc_d_next  = acc_d_reg;
        opd_n_next  = opd_n_reg;
        opd_d_next  = opd_d_reg;
        rn_next     = rn_reg;
        rd_next     = rd_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        res_n_next  = res_n_reg;
        res_d_next  = res_d_reg;
        res_eq_next = res_eq_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    opd_n_next  = opd_n;
                    opd_d_next  = opd_d;
                    res_eq_next = 1'b0;
                    phase_next  = 1'b0;
                    idx_next    = P_FIRST;
                    cnt_next    = '0;
                    unique case (cmd) inside
                        CMD_LOAD:
                        begin
                            acc_n_next = opd_n;
                            acc_d_next = opd_d;
                            res_n_next = opd_n;
                            res_d_next = opd_d;
                            state_next = ST_DONE;
                        end
                        CMD_CMP:
                        begin
                            res_n_next  = acc_n_reg;
                            res_d_next  = acc_d_reg;
                            res_eq_next = (acc_n_reg == opd_n) && (acc_d_reg == opd_d);
                            state_next  = ST_DONE;
                        end
                        CMD_ADD, CMD_MUL, CMD_ADD_NU, CMD_MUL_NU:
                        begin
                            state_next = ST_MLOAD;
                        end
                        CMD_PREINC:
                        begin
                            state_next = ST_INC;
                        end
                        CMD_POSTINC:
                        begin
                            // Reduce the old value first; it is the reply.
                            rn_next    = acc_n_reg;
                            rd_next    = acc_d_reg;
                            state_next = ST_RCHK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MLOAD:
            begin
                prod_next  = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
                case (idx_reg)
                    P_FIRST:
                    begin
                        mcand_next  = acc_n_reg;
                        mplier_next = is_add ? opd_d_reg : opd_n_reg;
                    end
                    P_CROSS:
                    begin
                        mcand_next  = acc_d_reg;
                        mplier_next = opd_n_reg;
                    end
                    default:
                    begin
                        mcand_next  = acc_d_reg;
                        mplier_next = opd_d_reg;
                    end
                endcase
            end
            ST_MUL:
            begin
                // One multiplier bit per cycle, product wraps at the word.
                prod_next   = alu_sum;
                mcand_next  = {mcand_reg[WORD_BITS-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[WORD_BITS-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next = '0;
                    case (idx_reg)
                        P_FIRST:
                        begin
                            rn_next    = alu_sum;
                            idx_next   = is_add ? P_CROSS : P_DEN;
                            state_next = ST_MLOAD;
                        end
                        P_CROSS:
                        begin
                            state_next = ST_ADDP;
                        end
                        default:
                        begin
                            rd_next    = alu_sum;
                            state_next = ST_RCHK;
                        end
                    endcase
                end
            end
            ST_ADDP:
            begin
                rn_next    = alu_sum;
                idx_next   = P_DEN;
                state_next = ST_MLOAD;
            end
            ST_INC:
            begin
                rn_next    = alu_sum;
                rd_next    = acc_d_reg;
                state_next = ST_RCHK;
            end
            ST_RCHK:
            begin
                // Reduce only when both terms are strictly positive.
                if (rn_pos && rd_pos)
                begin
                    ta_next    = rn_reg;
                    tb_next    = rd_reg;
                    k_next     = '0;
                    state_next = ST_GTWO;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_GTWO:
            begin
                if (!ta_reg[0] && !tb_reg[0])
                begin
                    ta_next = {1'b0, ta_reg[WORD_BITS-1:1]};
                    tb_next = {1'b0, tb_reg[WORD_BITS-1:1]};
                    k_next  = k_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (alu_sum == '0)
                begin
                    if (k_reg == '0)
                    begin
                        quo_next   = rn_reg;
                        rem_next   = '0;
                        cnt_next   = '0;
                        dsel_next  = 1'b0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_GSHL;
                    end
                end
                else if (!ta_reg[0])
                begin
                    ta_next = {1'b0, ta_reg[WORD_BITS-1:1]};
                end
                else if (!tb_reg[0])
                begin
                    tb_next = {1'b0, tb_reg[WORD_BITS-1:1]};
                end
                else if (alu_carry)
                begin
                    ta_next = alu_sum;
                end
                else
                begin
                    // Keep the larger term in ta for the next subtract.
                    ta_next = tb_reg;
                    tb_next = ta_reg;
                end
            end
            ST_GSHL:
            begin
                // Restore the common power of two, one bit a cycle.
                ta_next = {ta_reg[WORD_BITS-2:0], 1'b0};
                k_next  = k_reg - 1'b1;
                if (k_reg == K_W'(1))
                begin
                    quo_next   = rn_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    dsel_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring division by the gcd held in ta.
                rem_next = alu_carry ? alu_sum : div_shift;
                quo_next = quo_new;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (!dsel_reg)
                    begin
                        rn_next   = quo_new;
                        quo_next  = rd_reg;
                        dsel_next = 1'b1;
                    end
                    else
                    begin
                        rd_next    = quo_new;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (cmd_reg == CMD_POSTINC)
                begin
                    if (!phase_reg)
                    begin
                        res_n_next = rn_reg;
                        res_d_next = rd_reg;
                        phase_next = 1'b1;
                        state_next = ST_INC;
                    end
                    else
                    begin
                        acc_n_next = rn_reg;
                        acc_d_next = rd_reg;
                        phase_next = 1'b0;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    res_n_next = rn_reg;
                    res_d_next = rd_reg;
                    if (is_upd)
                    begin
                        acc_n_next = rn_reg;
                        acc_d_next = rd_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_LOAD;
            phase_reg <= 1'b0;
            idx_reg   <= P_FIRST;
            dsel_reg  <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            acc_n_reg <= '0;
            acc_d_reg <= WORD_BITS'(1);
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            dsel_reg  <= dsel_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            acc_n_reg <= acc_n_next;
            acc_d_reg <= acc_d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opd_n_reg  <= opd_n_next;
        opd_d_reg  <= opd_d_next;
        rn_reg     <= rn_next;
        rd_reg     <= rd_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        res_n_reg  <= res_n_next;
        res_d_reg  <= res_d_next;
        res_eq_reg <= res_eq_next;
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE) && out_free;
    assign res_n     = res_n_reg;
    assign res_d     = res_d_reg;
    assign res_eq    = res_eq_reg;

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD) |-> (ta_reg != '0 && tb_reg != '0))
        else $error("gcd loop running on a zero term");

    a_div_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (ta_reg != '0 && !ta_reg[WORD_BITS-1]))
        else $error("division by a divisor that is not positive");

    a_shl_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GSHL) |-> (k_reg != '0))
        else $error("gcd shift-back entered with no shift pending");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (state_reg == ST_IDLE))
        else $error("core did not return to idle after handing over a result");

endmodule

// ===== rtl/rational_accumulator_unit_top.sv =====
// Top level of the rational accumulator unit: stream ports and output register.
// Depends on rau_pkg and rau_core.
//
// Usage:
//   Slave channel (s_*) takes one command word: s_tuser is the command code,
//   s_tdata the operand fraction. Master channel (m_*) returns one result
//   word per command: s_tdata/m_tdata hold numerator then denominator, and
//   m_tuser is the compare flag.
//   The block holds one fraction (numerator / denominator, WORD_BITS wide).
//   Add and multiply run up to three shift-add products, one multiplier bit
//   a cycle, then reduce through a binary gcd loop and two restoring
//   divisions, all on one shared adder; post-increment runs two reductions.
//   s_tready is high only while the core is idle; one command is in flight.
//   Results land in an output register; a stalled receiver holds that word,
//   and the core waits with the next finished result until it drains.
//   Reset clears the fraction to 0/1 and empties the output register.
module rational_accumulator_unit_top #(
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_numerator, [63:32] operand_denominator
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] result_numerator, [63:32] result_denominator
    output logic        m_tuser    // [0] is_equal
);

    import rau_pkg::*;

    rau_stat_t            stat;
    logic                 start;
    logic                 out_free;
    logic [WORD_BITS-1:0] opd_n, opd_d;
    logic [WORD_BITS-1:0] res_n, res_d;
    logic                 res_eq;

    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_n_reg, m_n_next;
    logic [31:0]          m_d_reg, m_d_next;
    logic                 m_eq_reg, m_eq_next;

    // Fit the 32-bit operand fields to the internal word (sign extend or cut).
    assign opd_n = WORD_BITS'(signed'(s_tdata[31:0]));
    assign opd_d = WORD_BITS'(signed'(s_tdata[63:32]));

    assign s_tready = stat.idle;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    rau_core #(.WORD_BITS(WORD_BITS)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (s_tuser),
        .opd_n    (opd_n),
        .opd_d    (opd_d),
        .out_free (out_free),
        .stat     (stat),
        .res_n    (res_n),
        .res_d    (res_d),
        .res_eq   (res_eq)
    );

    // Output register: load a finished word, drop it once taken.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_n_next     = m_n_reg;
        m_d_next     = m_d_reg;
        m_eq_next    = m_eq_reg;
        if (stat.done)
        begin
            m_valid_next = 1'b1;
            m_n_next     = 32'(signed'(res_n));
            m_d_next     = 32'(signed'(res_d));
            m_eq_next    = res_eq;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_n_reg  <= m_n_next;
        m_d_reg  <= m_d_next;
        m_eq_reg <= m_eq_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_d_reg, m_n_reg};
    assign m_tuser  = m_eq_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a word still waiting");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready)
        else $error("ready stayed high after a command was taken");

    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (m_valid_reg && s_tready))
        else $error("handover did not fill the output register and free the core");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rational_accumulator_unit_top: directed corners, random
// command sequences under shifting idle profiles and a long output stall.
// Depends on rau_pkg and the RTL of the block; predicts every result word in-line.
module tb;

    import rau_pkg::*;

    // Numerator/denominator pair at the block's word width (32 bits here).
    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
    } frac_t;

    // One result word as the master channel returns it.
    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        eq;
    } frac_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // [31:0] operand_numerator, [63:32] operand_denominator
    logic [2:0]  s_tuser = '0;     // [2:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [31:0] result_numerator, [63:32] result_denominator
    logic        m_tuser;          // [0] is_equal

    // Predicted stored fraction and the words still owed by the block.
    frac_t       acc_frac;
    frac_word_t  owed_words[$];

    // Idle profiles, in percent of cycles, and the long receiver hold-off.
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_cycles = 0;

    int          words_sent = 0;
    int          words_checked = 0;
    int          equal_hits = 0;
    int          mismatch_count = 0;

    rational_accumulator_unit_top #(
        .WORD_BITS (32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #50_000_000;
        $display("timeout: %0d words still owed", owed_words.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fraction predictor
    // ------------------------------------------------------------------

    function automatic logic term_positive(logic [31:0] v);
        return (v != 32'd0) && !v[31];
    endfunction

    // Divide both terms by their gcd, but only when both are strictly positive;
    // zero or negative terms pass through untouched.
    function automatic frac_t reduce_frac(frac_t f);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        frac_t       r;
        r = f;
        if (term_positive(f.num) && term_positive(f.den))
        begin
            a = f.num;
            b = f.den;
            while (b != 32'd0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            r.num = f.num / a;
            r.den = f.den / a;
        end
        return r;
    endfunction

    // Work out the result word of one command and advance the stored fraction.
    // All sums and products wrap at 32 bits through the 32-bit targets.
    function automatic frac_word_t predict_word(rau_cmd_t c, logic [31:0] on, logic [31:0] od);
        frac_t      cur;
        frac_t      calc;
        frac_word_t w;
        cur  = acc_frac;
        calc = cur;
        w.eq = 1'b0;
        case (c)
            CMD_LOAD:
            begin
                calc.num = on;
                calc.den = od;
                acc_frac = calc;
            end
            CMD_ADD, CMD_ADD_NU:
            begin
                calc.num = cur.num * od + cur.den * on;
                calc.den = cur.den * od;
                calc     = reduce_frac(calc);
                if (c == CMD_ADD)
                    acc_frac = calc;
            end
            CMD_MUL, CMD_MUL_NU:
            begin
                calc.num = cur.num * on;
                calc.den = cur.den * od;
                calc     = reduce_frac(calc);
                if (c == CMD_MUL)
                    acc_frac = calc;
            end
            CMD_PREINC:
            begin
                calc.num = cur.num + cur.den;
                calc     = reduce_frac(calc);
                acc_frac = calc;
            end
            CMD_POSTINC:
            begin
                calc.num = cur.num + cur.den;
                acc_frac = reduce_frac(calc);
                // hand back the old value, reduced
                calc     = reduce_frac(cur);
            end
            default:
            begin
                // compare: stored value out unchanged, exact field match
                w.eq = (cur.num == on) && (cur.den == od);
            end
        endcase
        w.num = calc.num;
        w.den = calc.den;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Slave side: offer one command word and book its prediction on acceptance
    // ------------------------------------------------------------------

    task automatic send_word(input rau_cmd_t c, input logic [31:0] on, input logic [31:0] od);
        // drop valid for a random number of cycles per the sender profile
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {od, on};
        // hold the word until s_tready is seen high at an edge
        do
            @(posedge clk);
        while (!s_tready);
        owed_words.push_back(predict_word(c, on, od));
        words_sent++;
    endtask

    // Drop valid and wait until every owed word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (owed_words.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Master side: ready pattern and result checker
    // ------------------------------------------------------------------

    // Ready follows the receiver profile; a pending hold-off forces it low
    // and is counted down here, one cycle per edge.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        frac_word_t got_word;
        frac_word_t exp_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word.num = m_tdata[31:0];
            got_word.den = m_tdata[63:32];
            got_word.eq  = m_tuser;
            if (owed_words.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result word num=%h den=%h eq=%b",
                             $realtime, got_word.num, got_word.den, got_word.eq);
                mismatch_count++;
            end
            else
            begin
                exp_word = owed_words.pop_front();
                words_checked++;
                if (exp_word.eq)
                    equal_hits++;
                if (got_word.num !== exp_word.num || got_word.den !== exp_word.den ||
                    got_word.eq !== exp_word.eq)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: word %0d: expected num=%h den=%h eq=%b, got num=%h den=%h eq=%b",
                                 $realtime, words_checked, exp_word.num, exp_word.den,
                                 exp_word.eq, got_word.num, got_word.den, got_word.eq);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Operand generation
    // ------------------------------------------------------------------

    // Mostly small positive terms so reduction has work to do; some negatives,
    // zeros, full-range words and the two's-complement corners.
    function automatic logic [31:0] pick_term();
        logic [31:0] v;
        case ($urandom_range(15))
            9, 10:
            begin
                v = $urandom_range(64, 1);
                v = ~v + 32'd1;
            end
            11:      v = 32'd0;
            12, 13:  v = $urandom;
            14:
            begin
                case ($urandom_range(5))
                    0:       v = 32'h7fff_ffff;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'hffff_ffff;
                    3:       v = 32'h8000_0001;
                    4:       v = 32'h0000_0001;
                    default: v = 32'h0000_0000;
                endcase
            end
            15:      v = $urandom_range(32'h0001_0000, 1);
            default: v = $urandom_range(64, 1);
        endcase
        return v;
    endfunction

    // One well-formed run: load a fraction, then a short chain of arithmetic,
    // with compares that match the stored value about half the time.
    task automatic send_sequence();
        rau_cmd_t    c;
        logic [31:0] on;
        logic [31:0] od;
        int          ops;
        send_word(CMD_LOAD, pick_term(), pick_term());
        ops = $urandom_range(6, 1);
        repeat (ops)
        begin
            c  = rau_cmd_t'($urandom_range(CMD_MUL_NU, CMD_ADD));
            on = pick_term();
            od = pick_term();
            if (c == CMD_CMP && $urandom_range(1))
            begin
                on = acc_frac.num;
                od = acc_frac.den;
            end
            send_word(c, on, od);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked corners: reset value, every command, unreduced load,
    // zero denominator carried through, negative terms, wrap on overflow.
    task automatic test_directed_corners();
        send_word(CMD_CMP,     32'd0,          32'd1);           // fraction is 0/1 after reset
        send_word(CMD_CMP,     32'd0,          32'd0);
        send_word(CMD_LOAD,    32'd6,          32'd4);           // kept as 6/4
        send_word(CMD_CMP,     32'd6,          32'd4);
        send_word(CMD_ADD,     32'd1,          32'd4);
        send_word(CMD_MUL,     32'd2,          32'd3);
        send_word(CMD_PREINC,  32'hdead_beef,  32'h1234_5678);
        send_word(CMD_POSTINC, 32'd0,          32'd0);
        send_word(CMD_ADD_NU,  32'd1,          32'd6);
        send_word(CMD_MUL_NU,  32'd6,          32'd19);
        send_word(CMD_CMP,     32'd19,         32'd6);
        send_word(CMD_LOAD,    32'd3,          32'd0);           // zero denominator
        send_word(CMD_ADD,     32'd1,          32'd2);
        send_word(CMD_PREINC,  32'd0,          32'd0);
        send_word(CMD_LOAD,    32'hffff_fffc,  32'd8);           // negative numerator
        send_word(CMD_MUL,     32'd2,          32'd2);
        send_word(CMD_PREINC,  32'd0,          32'd0);
        send_word(CMD_LOAD,    32'h7fff_ffff,  32'd1);
        send_word(CMD_PREINC,  32'd0,          32'd0);           // wraps to most negative
        send_word(CMD_MUL,     32'h8000_0000,  32'hffff_ffff);
        send_word(CMD_LOAD,    32'h7fff_ffff,  32'h7fff_ffff);
        send_word(CMD_MUL,     32'h7fff_ffff,  32'h7fff_ffff);   // products wrap to 1/1
        send_word(CMD_LOAD,    32'h8000_0000,  32'h8000_0000);
        send_word(CMD_CMP,     32'h8000_0000,  32'h8000_0000);
        send_word(CMD_ADD_NU,  32'hffff_ffff,  32'hffff_ffff);
        drain_results();
    endtask

    // Random traffic under one idle profile: mostly well-formed runs,
    // the rest single words with random command and full-range operands.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = words_sent;
        while (words_sent - start < count)
        begin
            if ($urandom_range(7) == 0)
                send_word(rau_cmd_t'($urandom_range(7)), $urandom, $urandom);
            else
                send_sequence();
        end
        drain_results();
    endtask

    // Hold ready low for a long stretch while the sender keeps offering words,
    // so the output register and the core both fill and s_tready stalls.
    task automatic test_output_backpressure();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 3000;
        repeat (3)
            send_sequence();
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        acc_frac.num = 32'd0;
        acc_frac.den = 32'd1;
        // hold reset low, then release it on an edge
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 35;
        rx_idle_pct = 55;
        test_directed_corners();
        test_random_traffic(35, 55, 550);
        test_output_backpressure();
        test_random_traffic(55, 35, 550);
        test_random_traffic(0, 0, 550);

        // allow stray words to show up after the last expected one
        repeat (400)
            @(posedge clk);
        if (owed_words.size() != 0)
        begin
            $display("%0d result words never arrived", owed_words.size());
            mismatch_count += owed_words.size();
        end

        $display("summary: %0d command words sent, %0d results checked, %0d compare hits",
                 words_sent, words_checked, equal_hits);
        $display("summary: corners, random runs under three idle profiles, long output stall");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
